// ===== design/fkhm_pkg.sv =====
// fkhm_pkg: constants, types and the fnv-1 byte step for the key hash unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fkhm_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned KeyBytes = 8;
  localparam logic [63:0] FnvOffsetBasis = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3
  localparam int unsigned FnvPrimeShift = 40;
  localparam logic [8:0]  FnvPrimeLow   = 9'h1b3;
  localparam logic [7:0]  ByteMask      = 8'hff;

  // register indexes on the configuration port
  localparam logic RegTableSize = 1'b0;

  typedef struct packed {
    logic        valid;
    logic [63:0] hash;
  } fkhm_word_t;

  // one fnv-1 round: multiply by the prime modulo 2^64, then xor the byte
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] low;
    logic [63:0] prod;
    low  = h * {55'd0, FnvPrimeLow};
    prod = (h << FnvPrimeShift) + low;
    return prod ^ {56'd0, b & ByteMask};
  endfunction

endpackage
`default_nettype wire

// ===== design/fkhm_key_if.sv =====
// fkhm_key_if: key input channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface fkhm_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key;
  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface
`default_nettype wire

// ===== design/fkhm_bucket_if.sv =====
// fkhm_bucket_if: bucket result channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface fkhm_bucket_if;
  logic        valid;
  logic        ready;
  logic [63:0] bucket;
  modport source (output valid, output bucket, input ready);
  modport sink   (input valid, input bucket, output ready);
endinterface
`default_nettype wire

// ===== design/fkhm_fnv_pipe.sv =====
// fkhm_fnv_pipe: eight-stage fnv-1 hash pipeline, one key byte per stage
// depends on fkhm_pkg
`timescale 1ns / 1ps
`default_nettype none
module fkhm_fnv_pipe import fkhm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        valid_i,
  input  wire logic [63:0] key_i,
  output fkhm_word_t       word_o
);

  logic [KeyBytes-1:0] vld_q;
  logic [63:0]         hash_q [KeyBytes];
  logic [63:0]         key_q  [KeyBytes];

  // stage zero takes the offset basis and the lowest byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hash_q[0] <= fnv_step(FnvOffsetBasis, key_i[7:0]);
      key_q[0]  <= key_i;
    end
  end

  // later stages each fold in the next byte
  for (genvar s = 1; s < KeyBytes; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        hash_q[s] <= fnv_step(hash_q[s-1], key_q[s-1][8*s +: 8]);
        key_q[s]  <= key_q[s-1];
      end
    end
  end

  assign word_o.valid = vld_q[KeyBytes-1];
  assign word_o.hash  = hash_q[KeyBytes-1];

endmodule
`default_nettype wire

// ===== design/fkhm_mod_pipe.sv =====
// fkhm_mod_pipe: 64-stage restoring remainder pipeline, one hash bit per stage
// depends on fkhm_pkg
`timescale 1ns / 1ps
`default_nettype none
module fkhm_mod_pipe import fkhm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire fkhm_word_t  word_i,
  input  wire logic [63:0] table_size_i,
  output logic             valid_o,
  output logic [63:0]      bucket_o
);

  localparam int unsigned Stages = KeyW;

  logic [Stages-1:0] vld_q;
  logic [63:0]       hash_q [Stages];
  logic [63:0]       rem_q  [Stages];
  logic [63:0]       rem_d  [Stages];

  // one shift-and-subtract step per stage, hash bits from the top down
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [63:0] rem_in;
    logic [63:0] hash_in;
    logic        vld_in;
    logic [64:0] trial;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign hash_in = word_i.hash;
      assign vld_in  = word_i.valid;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign hash_in = hash_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    always_comb begin
      trial = {rem_in, hash_in[Stages-1-s]};
      if (trial >= {1'b0, table_size_i}) begin
        trial = trial - {1'b0, table_size_i};
      end
      rem_d[s] = trial[63:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        hash_q[s] <= hash_in;
        rem_q[s]  <= rem_d[s];
      end
    end
  end

  // a zero size means no reduction
  assign valid_o  = vld_q[Stages-1];
  assign bucket_o = (table_size_i == '0) ? hash_q[Stages-1] : rem_q[Stages-1];

endmodule
`default_nettype wire

// ===== design/fnv1_key_hash_modulo_unit.sv =====
// fnv1_key_hash_modulo_unit: top level, apb register and the two pipelines
// depends on fkhm_pkg, fkhm_key_if, fkhm_bucket_if, fkhm_fnv_pipe, fkhm_mod_pipe
`timescale 1ns / 1ps
`default_nettype none
// Hashes one 64-bit key per word with 64-bit FNV-1 (bytes least significant
// first) and returns the hash modulo table_size. A new key is taken every
// cycle unless the output stalls; each word passes eight hash stages, one per
// key byte, then 64 remainder stages, one hash bit each. A stall at the
// output freezes the whole pipe. table_size sits at APB address 0 (64-bit
// data, reset 1); the user must write it only while the pipe is empty and
// the block does not enforce this; a zero size passes the hash unreduced.
module fnv1_key_hash_modulo_unit import fkhm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  fkhm_key_if.sink         key_i,
  fkhm_bucket_if.source    bucket_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] table_size_q;
  logic        adv;
  logic        out_vld;
  fkhm_word_t  fnv_word;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= 64'd1;
    end else if (psel && penable && pwrite && (paddr == {RegTableSize, 3'b000})) begin
      table_size_q <= pwdata;
    end
  end

  assign prdata = (paddr == {RegTableSize, 3'b000}) ? table_size_q : '0;

  // global advance: move unless the output word is held
  assign adv         = !out_vld || bucket_o.ready;
  assign key_i.ready = adv;

  fkhm_fnv_pipe u_fnv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (key_i.valid),
    .key_i   (key_i.key),
    .word_o  (fnv_word)
  );

  fkhm_mod_pipe u_mod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .word_i       (fnv_word),
    .table_size_i (table_size_q),
    .valid_o      (out_vld),
    .bucket_o     (bucket_o.bucket)
  );

  assign bucket_o.valid = out_vld;

  // checks
  a_bucket_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld && (table_size_q != '0)) |-> (bucket_o.bucket < table_size_q))
    else $error("bucket not below table size");

  a_hash_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && fnv_word.valid) |=> ($stable(fnv_word.hash) && fnv_word.valid))
    else $error("hash word changed during stall");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld |-> key_i.ready)
    else $error("input blocked with empty output");

endmodule
`default_nettype wire
